@@ rtl/core/sha256_message_digest_defines.svh @@
// Assertion macros shared by the SHA-256 digest RTL.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/sha_pkg.sv @@
// Package: SHA-256 constants, types and round functions.
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_GATHER,
    ST_PAD,
    ST_START,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic        load_word;   // write word_in into window at pos
    logic [31:0] word_in;
    logic        start_block; // copy hash into working vars
    logic        do_round;    // one compression round
    logic        finish;      // fold working vars into hash
    logic        reset_hash;  // back to the initial vector
  } dp_cmd_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_vec(input logic [2:0] i);
    case (i)
      3'd0: init_vec = 32'h6a09e667;
      3'd1: init_vec = 32'hbb67ae85;
      3'd2: init_vec = 32'h3c6ef372;
      3'd3: init_vec = 32'ha54ff53a;
      3'd4: init_vec = 32'h510e527f;
      3'd5: init_vec = 32'h9b05688c;
      3'd6: init_vec = 32'h1f83d9ab;
      default: init_vec = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ rtl/core/sha_if.sv @@
// Interfaces: message word input channel and digest word output channel.
interface sha_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

@@ rtl/core/sha_datapath.sv @@
// Datapath: message schedule window, working variables, hash state, round logic.
`include "sha256_message_digest_defines.svh"
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::dp_cmd_t  cmd,
  input  logic [3:0]        pos,
  input  logic [5:0]        round,
  input  logic [2:0]        rd_index,
  output logic [31:0]       rd_word
);

  logic [31:0] window [16];
  logic [31:0] wv [8];
  logic [31:0] hash [8];

  logic [31:0] w_new, w_cur, t1, t2;

  // Schedule expansion and round sums
  always_comb begin
    w_new = sha_pkg::small_s1(window[pos + 4'd14]) + window[pos + 4'd9]
          + sha_pkg::small_s0(window[pos + 4'd1]) + window[pos];
    w_cur = (round[5:4] == 2'd0) ? window[pos] : w_new;
    t1 = wv[7] + sha_pkg::big_s1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + sha_pkg::RoundK[round] + w_cur;
    t2 = sha_pkg::big_s0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // Window: written by incoming words and by expansion
  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      window[pos] <= cmd.word_in;
    end else if (cmd.do_round && round[5:4] != 2'd0) begin
      window[pos] <= w_new;
    end
  end

  // Working variables: a..h shift by one, e and a take the new sums
  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash[i];
    end else if (cmd.do_round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  // Hash state
  always_ff @(posedge clk) begin
    if (rst || cmd.reset_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::init_vec(3'(i));
    end else if (cmd.finish) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
    end
  end

  assign rd_word = hash[rd_index];

  `SHA_ASSERT_IMP(a_cmd_excl, cmd.load_word, !cmd.do_round && !cmd.start_block)
  `SHA_ASSERT_IMP(a_fin_excl, cmd.finish, !cmd.do_round && !cmd.reset_hash)
  `SHA_ASSERT_NXT(a_reset_iv, cmd.reset_hash, hash[0] == 32'h6a09e667)

endmodule

@@ rtl/core/sha_ctrl.sv @@
// Controller: word gathering, padding, round sequencing and digest output.
`include "sha256_message_digest_defines.svh"
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  sha_in_if.sink            in_ch,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [2:0]        out_index,
  output sha_pkg::dp_cmd_t  cmd,
  output logic [3:0]        pos,
  output logic [5:0]        round
);

  sha_pkg::ctrl_state_t state, state_next;
  logic [63:0] bit_count, bit_count_next;
  logic [3:0]  pos_next;
  logic [5:0]  round_next;
  logic [2:0]  out_index_next;
  logic        padding, padding_next;   // message ended, padding under way
  logic        marker, marker_next;     // 0x80 word still owed
  logic        len_hi, len_hi_next;     // length placed in this block: last block
  logic        accept;
  logic [2:0]  nb;
  logic [31:0] keep, tail;
  logic [63:0] len_now;

  // Tail word: keep valid bytes, put 0x80 right after them
  always_comb begin
    nb = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
    case (nb)
      3'd1: keep = 32'hff000000;
      3'd2: keep = 32'hffff0000;
      3'd3: keep = 32'hffffff00;
      default: keep = 32'h00000000;
    endcase
    case (nb)
      3'd1: tail = (in_ch.data_word & keep) | 32'h00800000;
      3'd2: tail = (in_ch.data_word & keep) | 32'h00008000;
      3'd3: tail = (in_ch.data_word & keep) | 32'h00000080;
      default: tail = 32'h80000000;
    endcase
    len_now = bit_count + {58'd0, nb, 3'd0};
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_GATHER;
      bit_count <= '0;
      pos <= '0;
      round <= '0;
      out_index <= '0;
      padding <= 1'b0;
      marker <= 1'b0;
      len_hi <= 1'b0;
    end else begin
      state <= state_next;
      bit_count <= bit_count_next;
      pos <= pos_next;
      round <= round_next;
      out_index <= out_index_next;
      padding <= padding_next;
      marker <= marker_next;
      len_hi <= len_hi_next;
    end
  end

  always_comb begin
    state_next = state;
    bit_count_next = bit_count;
    pos_next = pos;
    round_next = round;
    out_index_next = out_index;
    padding_next = padding;
    marker_next = marker;
    len_hi_next = len_hi;
    cmd = '0;
    in_ch.ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      sha_pkg::ST_GATHER: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          cmd.load_word = 1'b1;
          pos_next = pos + 4'd1;
          if (!in_ch.last_word) begin
            cmd.word_in = in_ch.data_word;
            bit_count_next = bit_count + 64'd32;
          end else begin
            bit_count_next = len_now;
            padding_next = 1'b1;
            if (nb == 3'd4) begin
              cmd.word_in = in_ch.data_word;
              marker_next = 1'b1;
            end else begin
              cmd.word_in = tail;
            end
          end
          if (pos == 4'd15) begin
            state_next = sha_pkg::ST_START;
          end else if (in_ch.last_word) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // Padding words: marker, zero fill, then the 64-bit length
        cmd.load_word = 1'b1;
        pos_next = pos + 4'd1;
        if (marker) begin
          cmd.word_in = 32'h80000000;
          marker_next = 1'b0;
        end else if (pos == 4'd14) begin
          cmd.word_in = bit_count[63:32];
          len_hi_next = 1'b1;
        end else if (pos == 4'd15 && len_hi) begin
          cmd.word_in = bit_count[31:0];
        end else begin
          cmd.word_in = 32'h0;
        end
        if (pos == 4'd15) begin
          state_next = sha_pkg::ST_START;
        end
      end
      sha_pkg::ST_START: begin
        cmd.start_block = 1'b1;
        state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        // One round per cycle; pos walks the window slot with the round
        cmd.do_round = 1'b1;
        round_next = round + 6'd1;
        pos_next = pos + 4'd1;
        if (round == 6'd63) begin
          state_next = sha_pkg::ST_FINISH;
        end
      end
      sha_pkg::ST_FINISH: begin
        // Fold the block in, then emit, pad on or gather
        cmd.finish = 1'b1;
        if (len_hi) begin
          out_index_next = 3'd0;
          state_next = sha_pkg::ST_EMIT;
        end else if (padding) begin
          state_next = sha_pkg::ST_PAD;
        end else begin
          state_next = sha_pkg::ST_GATHER;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          out_index_next = out_index + 3'd1;
          if (out_index == 3'd7) begin
            cmd.reset_hash = 1'b1;
            bit_count_next = '0;
            padding_next = 1'b0;
            len_hi_next = 1'b0;
            pos_next = '0;
            state_next = sha_pkg::ST_GATHER;
          end
        end
      end
      default: state_next = sha_pkg::ST_GATHER;
    endcase
  end

  `SHA_ASSERT_IMP(a_rdy_gather, in_ch.ready, state == sha_pkg::ST_GATHER)
  `SHA_ASSERT_IMP(a_out_emit, out_valid, state == sha_pkg::ST_EMIT)
  `SHA_ASSERT_IMP(a_pos_align, state == sha_pkg::ST_ROUND, pos == round[3:0])
  `SHA_ASSERT_NXT(a_round_wrap, state == sha_pkg::ST_ROUND && round == 6'd63,
                  state == sha_pkg::ST_FINISH)

endmodule

@@ rtl/core/sha256_message_digest.sv @@
// Top level: SHA-256 digest of one message, controller plus datapath.
//   channel  dir  beat
//   in_ch    in   data_word[31:0], valid_bytes[2:0], last_word
//   out_ch   out  digest_word[31:0], word_index[2:0], digest_last
// A full 16-word block takes 16 input beats, then one load of the working vars, 64 rounds
// and one fold. The last word adds padding up to the 64-bit length and one or two blocks,
// then eight digest beats.
// rst (synchronous) restores the initial vector and clears the bit count.
// Input is not taken while rounds run or digest beats are pending.
module sha256_message_digest (
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::dp_cmd_t cmd;
  logic [3:0] pos;
  logic [5:0] round;
  logic [2:0] out_index;
  logic       out_valid;
  logic [31:0] rd_word;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ready(out_ch.ready),
    .out_valid(out_valid), .out_index(out_index), .cmd(cmd), .pos(pos),
    .round(round)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .pos(pos), .round(round),
    .rd_index(out_index), .rd_word(rd_word)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = rd_word;
  assign out_ch.word_index  = out_index;
  assign out_ch.digest_last = (out_index == 3'd7);

endmodule
